[design/msie_pkg.sv]
package msie_pkg;

    localparam int DataWordsDefault = 1024;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_MULT = 6'd24;
    localparam logic [5:0] FN_DIV  = 6'd26;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_SLT  = 6'd42;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_ADDR    = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    // control handed to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctrl_t;

endpackage

[design/mips_subset_instruction_executor_unit.sv]
// simple instructions: execute state, then output register, from accept to result
// lw adds the load state for the registered memory read
// mult and div wait in the multiply/divide state on the shared shift-add/subtract unit
// one word at a time: the next word is accepted once the result leaves
// reset: a clearing pass writes zero to every data word,
// no word accepted until it ends; registers, hi, lo and index read as zero
module mips_subset_instruction_executor_unit
#(
    parameter int DATA_WORDS = msie_pkg::DataWordsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         instruction_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  next_index,
    output logic                reg_write_enable,
    output logic [4:0]          reg_write_number,
    output logic [31:0]         reg_write_data,
    output logic [31:0]         hi_value,
    output logic [31:0]         lo_value,
    output logic [1:0]          status
);
    import msie_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_MD    = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [31:0]   ir_reg;
    logic [31:0]   a_reg, b_reg;
    logic [31:0]   pc_reg, pc_next;
    logic [31:0]   hi_reg, hi_next, lo_reg, lo_next;
    logic [31:0]   gpr [32];
    logic [31:0]   dmem [DATA_WORDS];
    logic [31:0]   mem_rd_reg;
    logic          ov_reg;
    logic          o_we_reg, o_we_next;
    logic [4:0]    o_num_reg, o_num_next;
    logic [31:0]   o_data_reg, o_data_next;
    logic [1:0]    o_st_reg, o_st_next;
    logic          rf_we;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    md_ctrl_t      md_ctrl;
    logic          md_done;
    logic [31:0]   md_hi, md_lo;

    logic [5:0]  op, fn;
    logic [4:0]  rt, rd;
    logic [31:0] simm, addr, pc1;
    logic        addr_ok;

    assign op   = ir_reg[31:26];
    assign fn   = ir_reg[5:0];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign addr = a_reg + simm;
    assign pc1  = pc_reg + 32'd1;
    assign addr_ok = !addr[31] && (addr < 32'(DATA_WORDS));
    assign mem_addr = addr[AW-1:0];

    msie_muldiv u_md
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (md_ctrl),
        .op_a  (a_reg),
        .op_b  (b_reg),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pc_next     = pc_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        o_we_next   = 1'b0;
        o_num_next  = 5'd0;
        o_data_next = 32'd0;
        o_st_next   = ST_OK;
        md_ctrl     = '0;
        mem_we      = 1'b0;
        mem_waddr   = mem_addr;
        mem_wdata   = b_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                mem_wdata = 32'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DATA_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                pc_next    = pc1;
                case (op)
                    OP_SPECIAL:
                    begin
                        case (fn)
                            FN_JR:   pc_next = a_reg;
                            FN_MULT, FN_DIV:
                            begin
                                if (fn == FN_DIV && b_reg == 32'd0)
                                begin
                                    hi_next   = 32'd0;
                                    lo_next   = a_reg;
                                    o_st_next = ST_DIVZERO;
                                end
                                else
                                begin
                                    md_ctrl.start  = 1'b1;
                                    md_ctrl.is_div = (fn == FN_DIV);
                                    state_next     = S_MD;
                                end
                            end
                            FN_ADD:
                            begin
                                o_num_next  = rd;
                                o_data_next = a_reg + b_reg;
                            end
                            FN_SUB:
                            begin
                                o_num_next  = rd;
                                o_data_next = a_reg - b_reg;
                            end
                            FN_AND:
                            begin
                                o_num_next  = rd;
                                o_data_next = a_reg & b_reg;
                            end
                            FN_OR:
                            begin
                                o_num_next  = rd;
                                o_data_next = a_reg | b_reg;
                            end
                            FN_SLT:
                            begin
                                o_num_next  = rd;
                                o_data_next = {31'd0, $signed(a_reg) < $signed(b_reg)};
                            end
                            default: o_st_next = ST_UNKNOWN;
                        endcase
                    end
                    OP_J:    pc_next = {6'd0, ir_reg[25:0]};
                    OP_JAL:
                    begin
                        pc_next     = {6'd0, ir_reg[25:0]};
                        o_num_next  = 5'd31;
                        o_data_next = pc1;
                    end
                    OP_BEQ:  if (a_reg == b_reg) pc_next = pc_reg + simm;
                    OP_BNE:  if (a_reg != b_reg) pc_next = pc_reg + simm;
                    OP_ADDI:
                    begin
                        o_num_next  = rt;
                        o_data_next = addr;
                    end
                    OP_LW, OP_SW:
                    begin
                        if (!addr_ok)
                            o_st_next = ST_ADDR;
                        else if (op == OP_LW)
                            state_next = S_LOAD;
                        else
                            mem_we = 1'b1;
                    end
                    default: o_st_next = ST_UNKNOWN;
                endcase
                o_we_next = (o_num_next != 5'd0);
                if (o_num_next == 5'd0)
                    o_data_next = 32'd0;
            end
            S_MD:
            begin
                if (md_done)
                begin
                    hi_next    = md_hi;
                    lo_next    = md_lo;
                    state_next = S_OUT;
                end
            end
            S_LOAD:
            begin
                o_num_next  = rt;
                o_we_next   = (rt != 5'd0);
                o_data_next = (rt != 5'd0) ? mem_rd_reg : 32'd0;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign rf_we = (state_reg == S_EXEC || state_reg == S_LOAD) && o_we_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= 32'd0;
            hi_reg    <= 32'd0;
            lo_reg    <= 32'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            ov_reg    <= (state_next == S_OUT);
        end
    end

    // general registers: valid-bit free, cleared by reset since 32 entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                gpr[i] <= 32'd0;
        end
        else if (rf_we)
            gpr[o_num_next] <= o_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            ir_reg <= instruction_word;
            a_reg  <= gpr[instruction_word[25:21]];
            b_reg  <= gpr[instruction_word[20:16]];
        end
        if (state_reg == S_EXEC || state_reg == S_LOAD || state_reg == S_MD)
        begin
            o_we_reg   <= o_we_next;
            o_num_reg  <= o_num_next;
            o_data_reg <= o_data_next;
            o_st_reg   <= o_st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            dmem[mem_waddr] <= mem_wdata;
        mem_rd_reg <= dmem[mem_addr];
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = ov_reg;
    assign next_index       = pc_reg;
    assign reg_write_enable = o_we_reg;
    assign reg_write_number = o_num_reg;
    assign reg_write_data   = o_data_reg;
    assign hi_value         = hi_reg;
    assign lo_value         = lo_reg;
    assign status           = o_st_reg;

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid == (state_reg == S_OUT)) else $error("valid out of step");
    a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write_enable |-> reg_write_number != 5'd0)
        else $error("r0 written");
    a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        gpr[0] == 32'd0) else $error("r0 not zero");
    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pc_reg)) else $error("index moved");

endmodule

[design/msie_muldiv.sv]
module msie_muldiv
(
    input  logic                clk,
    input  logic                rst_n,
    input  msie_pkg::md_ctrl_t  ctrl,
    input  logic [31:0]         op_a,
    input  logic [31:0]         op_b,
    output logic                done,
    output logic [31:0]         hi,
    output logic [31:0]         lo
);
    import msie_pkg::*;

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] b_reg, b_next;
    logic [32:0] sum;
    logic [31:0] rem_sh;
    logic [31:0] diff;

    // a 33-bit adder does shift-add for mult, a 32-bit trial subtract does div
    always_comb
    begin
        rem_sh = {hi_reg[30:0], lo_reg[31]};
        diff   = rem_sh - b_reg;
        sum    = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? b_reg : 32'd0)};
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            div_next  = ctrl.is_div;
            cnt_next  = 6'd0;
            hi_next   = 32'd0;
            lo_next   = op_a;
            b_next    = op_b;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                hi_next = diff[31] ? rem_sh : diff;
                lo_next = {lo_reg[30:0], ~diff[31]};
            end
            else
            begin
                hi_next = sum[32:1];
                lo_next = {sum[0], lo_reg[31:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd31);
    assign hi   = hi_next;
    assign lo   = lo_next;

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !done) else $error("done while idle");
    a_done_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ctrl.start |=> !busy_reg) else $error("busy after done");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'd32) else $error("count out of range");

endmodule
